>>> rtl/tts_pkg.sv
// Shared types and constants of the two-track step sequencer.
package tts_pkg;

	// Command codes carried in the func field of an input item.
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_STOP  = 2'd2,
		FUNC_WRITE = 2'd3
	} func_t;

	// Playback order of a track.
	typedef enum logic [1:0] {
		DIR_FORWARD  = 2'd0,
		DIR_BACKWARD = 2'd1,
		DIR_BOUNCE   = 2'd2,
		DIR_JUMP     = 2'd3
	} dir_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_TEMPO_BPM       = 3'd0,
		CFG_LENGTH_LEFT     = 3'd1,
		CFG_LENGTH_RIGHT    = 3'd2,
		CFG_DIRECTION_LEFT  = 3'd3,
		CFG_DIRECTION_RIGHT = 3'd4
	} cfg_idx_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 10;

	// Accumulator wrap value for one sequencer step.
	localparam logic [12:0] STEP_PERIOD = 13'd3600;

	// Reset values of the configuration registers.
	localparam logic [9:0] TEMPO_RESET  = 10'd120;
	localparam logic [4:0] LENGTH_RESET = 5'd16;

	// One input item.
	typedef struct packed {
		logic [1:0] func;
		logic       track_sel;
		logic [3:0] step_index;
		logic       step_trigger;
		logic [6:0] step_probability;
		logic [6:0] roll_left;
		logic [6:0] roll_right;
		logic [3:0] jump_left;
		logic [3:0] jump_right;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic       stepped;
		logic       fire_left;
		logic       fire_right;
		logic [3:0] played_left;
		logic [3:0] played_right;
		logic       silence_all;
	} res_t;

	// One entry of the step table.
	typedef struct packed {
		logic       trigger;
		logic [6:0] probability;
	} step_entry_t;

endpackage

>>> rtl/tts_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface tts_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/two_track_step_sequencer_unit.sv
// Top level of the two-track step sequencer: command stage, sequencing logic, result register.
//
//  channel | role   | payload      | accepted when
//  --------+--------+--------------+-------------------------------------
//  cmd     | sink   | tts_pkg::cmd_t | cmd.valid && cmd.ready at clk rise
//  res     | source | tts_pkg::res_t | res.valid && res.ready at clk rise
//  cfg     | write  | index, data  | cfg_we at clk rise
//
// Each item passes through the command register and then the result register, which offers
// its result; one item is taken per cycle while the result is not stalled.
// The tempo clamp, the accumulator add and compare, which select the position update,
// set the cycle path.
// arst_n clears the valid flags, sequencer state and step table, and presets the configuration registers.
// A stalled result holds the command stage, which in turn lowers cmd.ready.
module two_track_step_sequencer_unit #(
	parameter int unsigned MAX_STEPS = 16,
	parameter int unsigned BPM_LOW   = 40,
	parameter int unsigned BPM_HIGH  = 300
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tts_stream_if.sink                      cmd,
	tts_stream_if.source                    res,
	input  logic                            cfg_we,
	input  logic [tts_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tts_pkg::*;

	localparam int unsigned PW = $clog2(MAX_STEPS);

	typedef struct packed {
		logic          up;
		logic [PW-1:0] pos;
	} trk_t;

	// Configuration registers.
	logic [9:0] tempo_bpm_q;
	logic [4:0] length_left_q;
	logic [4:0] length_right_q;
	dir_t       direction_left_q;
	dir_t       direction_right_q;

	// Sequencer state.
	logic          playing_q;
	logic [11:0]   tick_sum_q;
	logic [PW-1:0] pos_left_q;
	logic [PW-1:0] pos_right_q;
	logic          up_left_q;
	logic          up_right_q;
	step_entry_t   step_left_q  [MAX_STEPS];
	step_entry_t   step_right_q [MAX_STEPS];

	// Pipeline registers.
	logic valid_s1;
	cmd_t cmd_s1;
	logic res_valid_q;
	res_t res_q;

	// Combinational results of the command stage.
	logic        advance;
	func_t       func;
	logic [9:0]  bpm;
	logic [12:0] sum;
	logic        step_hit;
	logic [12:0] next_sum;
	logic [6:0]  idx_ext;
	logic        write_ok;
	step_entry_t entry_left;
	step_entry_t entry_right;
	trk_t        next_left;
	trk_t        next_right;
	res_t        res_d;

	// Next position and pendulum direction of one track after a step.
	function automatic trk_t step_track(input logic [PW-1:0] pos, input logic up,
			input logic [4:0] len_reg, input dir_t dir, input logic [3:0] jump);
		logic [6:0] len;
		logic [6:0] pos_e;
		logic [6:0] jmp_e;
		trk_t       r;
		len   = ({2'b00, len_reg} > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : {2'b00, len_reg};
		pos_e = 7'(pos);
		jmp_e = {3'b000, jump};
		r.up  = up;
		r.pos = pos;
		if (len <= 7'd1) begin
			r.pos = '0;
		end else begin
			unique case (dir)
				DIR_FORWARD: begin
					r.pos = (pos_e + 7'd1 >= len) ? '0 : PW'(pos_e + 7'd1);
				end
				DIR_BACKWARD: begin
					r.pos = (pos_e == 7'd0) ? PW'(len - 7'd1) : PW'(pos_e - 7'd1);
				end
				DIR_BOUNCE: begin
					if (up) begin
						if (pos_e >= len - 7'd1) begin
							r.up  = 1'b0;
							r.pos = PW'(len - 7'd2);
						end else begin
							r.pos = PW'(pos_e + 7'd1);
						end
					end else begin
						if (pos_e == 7'd0) begin
							r.up  = 1'b1;
							r.pos = PW'(7'd1);
						end else begin
							r.pos = PW'(pos_e - 7'd1);
						end
					end
				end
				DIR_JUMP: begin
					r.pos = (jmp_e > len - 7'd1) ? PW'(len - 7'd1) : PW'(jmp_e);
				end
			endcase
		end
		return r;
	endfunction

	// A step sounds when it has a trigger, a non-zero chance and the roll is below it.
	function automatic logic step_fires(input step_entry_t e, input logic [6:0] roll);
		return e.trigger && (e.probability != 7'd0) && (roll < e.probability);
	endfunction

	// The command stage moves on when the result register is free or being emptied.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// Command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	// Tempo accumulator and step decision.
	always_comb begin
		func = func_t'(cmd_s1.func);
		bpm  = tempo_bpm_q;
		if (bpm < 10'(BPM_LOW)) begin
			bpm = 10'(BPM_LOW);
		end
		if (bpm > 10'(BPM_HIGH)) begin
			bpm = 10'(BPM_HIGH);
		end
		sum      = {1'b0, tick_sum_q} + {1'b0, bpm, 2'b00};
		step_hit = (sum >= STEP_PERIOD);
		next_sum = step_hit ? (sum - STEP_PERIOD) : sum;
	end

	// Table reads at the current positions and the next track positions.
	always_comb begin
		entry_left  = step_left_q[pos_left_q];
		entry_right = step_right_q[pos_right_q];
		next_left   = step_track(pos_left_q, up_left_q, length_left_q, direction_left_q,
				cmd_s1.jump_left);
		next_right  = step_track(pos_right_q, up_right_q, length_right_q, direction_right_q,
				cmd_s1.jump_right);
		idx_ext     = {3'b000, cmd_s1.step_index};
		write_ok    = (idx_ext < 7'(MAX_STEPS));
	end

	// Result of the item in the command stage.
	always_comb begin
		res_d = '0;
		unique case (func)
			FUNC_TICK: begin
				if (playing_q && step_hit) begin
					res_d.stepped      = 1'b1;
					res_d.fire_left    = step_fires(entry_left, cmd_s1.roll_left);
					res_d.fire_right   = step_fires(entry_right, cmd_s1.roll_right);
					res_d.played_left  = 4'(pos_left_q);
					res_d.played_right = 4'(pos_right_q);
				end
			end
			FUNC_STOP: begin
				res_d.silence_all = 1'b1;
			end
			FUNC_START, FUNC_WRITE: begin
				res_d = '0;
			end
		endcase
	end

	// Sequencer state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q   <= 1'b0;
			tick_sum_q  <= '0;
			pos_left_q  <= '0;
			pos_right_q <= '0;
			up_left_q   <= 1'b1;
			up_right_q  <= 1'b1;
		end else if (advance) begin
			unique case (func)
				FUNC_START: begin
					playing_q   <= 1'b1;
					tick_sum_q  <= '0;
					pos_left_q  <= '0;
					pos_right_q <= '0;
					up_left_q   <= 1'b1;
					up_right_q  <= 1'b1;
				end
				FUNC_STOP: begin
					playing_q <= 1'b0;
				end
				FUNC_TICK: begin
					if (playing_q) begin
						tick_sum_q <= next_sum[11:0];
						if (step_hit) begin
							pos_left_q  <= next_left.pos;
							up_left_q   <= next_left.up;
							pos_right_q <= next_right.pos;
							up_right_q  <= next_right.up;
						end
					end
				end
				FUNC_WRITE: begin
					playing_q <= playing_q;
				end
			endcase
		end
	end

	// Step table, cleared by reset and written by write commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(MAX_STEPS); i++) begin
				step_left_q[i]  <= '0;
				step_right_q[i] <= '0;
			end
		end else if (advance && (func == FUNC_WRITE) && write_ok) begin
			if (cmd_s1.track_sel) begin
				step_right_q[idx_ext[PW-1:0]] <= {cmd_s1.step_trigger, cmd_s1.step_probability};
			end else begin
				step_left_q[idx_ext[PW-1:0]] <= {cmd_s1.step_trigger, cmd_s1.step_probability};
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_bpm_q       <= TEMPO_RESET;
			length_left_q     <= LENGTH_RESET;
			length_right_q    <= LENGTH_RESET;
			direction_left_q  <= DIR_FORWARD;
			direction_right_q <= DIR_FORWARD;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TEMPO_BPM:       tempo_bpm_q       <= cfg_data;
				CFG_LENGTH_LEFT:     length_left_q     <= cfg_data[4:0];
				CFG_LENGTH_RIGHT:    length_right_q    <= cfg_data[4:0];
				CFG_DIRECTION_LEFT:  direction_left_q  <= dir_t'(cfg_data[1:0]);
				CFG_DIRECTION_RIGHT: direction_right_q <= dir_t'(cfg_data[1:0]);
				default: begin
					tempo_bpm_q <= tempo_bpm_q;
				end
			endcase
		end
	end

endmodule
